[rtl/des_pkg.sv]
`timescale 1ns / 1ps
package des_pkg;

   localparam int BlockWidth = 64;
   localparam int HalfWidth  = 32;
   localparam int KeyWidth   = 64;
   localparam int SubWidth   = 48;
   localparam int CdWidth    = 56;
   localparam int HalfKey    = 28;
   localparam int Rounds     = 16;

   typedef logic [7:0] idx_type;

   localparam idx_type TAB_IP [64] = '{
      8'd58,8'd50,8'd42,8'd34,8'd26,8'd18,8'd10,8'd2, 8'd60,8'd52,8'd44,8'd36,8'd28,8'd20,8'd12,8'd4,
      8'd62,8'd54,8'd46,8'd38,8'd30,8'd22,8'd14,8'd6, 8'd64,8'd56,8'd48,8'd40,8'd32,8'd24,8'd16,8'd8,
      8'd57,8'd49,8'd41,8'd33,8'd25,8'd17,8'd9,8'd1,  8'd59,8'd51,8'd43,8'd35,8'd27,8'd19,8'd11,8'd3,
      8'd61,8'd53,8'd45,8'd37,8'd29,8'd21,8'd13,8'd5, 8'd63,8'd55,8'd47,8'd39,8'd31,8'd23,8'd15,8'd7};

   localparam idx_type TAB_FP [64] = '{
      8'd40,8'd8,8'd48,8'd16,8'd56,8'd24,8'd64,8'd32, 8'd39,8'd7,8'd47,8'd15,8'd55,8'd23,8'd63,8'd31,
      8'd38,8'd6,8'd46,8'd14,8'd54,8'd22,8'd62,8'd30, 8'd37,8'd5,8'd45,8'd13,8'd53,8'd21,8'd61,8'd29,
      8'd36,8'd4,8'd44,8'd12,8'd52,8'd20,8'd60,8'd28, 8'd35,8'd3,8'd43,8'd11,8'd51,8'd19,8'd59,8'd27,
      8'd34,8'd2,8'd42,8'd10,8'd50,8'd18,8'd58,8'd26, 8'd33,8'd1,8'd41,8'd9,8'd49,8'd17,8'd57,8'd25};

   localparam idx_type TAB_E [48] = '{
      8'd32,8'd1,8'd2,8'd3,8'd4,8'd5, 8'd4,8'd5,8'd6,8'd7,8'd8,8'd9,
      8'd8,8'd9,8'd10,8'd11,8'd12,8'd13, 8'd12,8'd13,8'd14,8'd15,8'd16,8'd17,
      8'd16,8'd17,8'd18,8'd19,8'd20,8'd21, 8'd20,8'd21,8'd22,8'd23,8'd24,8'd25,
      8'd24,8'd25,8'd26,8'd27,8'd28,8'd29, 8'd28,8'd29,8'd30,8'd31,8'd32,8'd1};

   localparam idx_type TAB_P [32] = '{
      8'd16,8'd7,8'd20,8'd21,8'd29,8'd12,8'd28,8'd17, 8'd1,8'd15,8'd23,8'd26,8'd5,8'd18,8'd31,8'd10,
      8'd2,8'd8,8'd24,8'd14,8'd32,8'd27,8'd3,8'd9,    8'd19,8'd13,8'd30,8'd6,8'd22,8'd11,8'd4,8'd25};

   localparam idx_type TAB_PC1 [56] = '{
      8'd57,8'd49,8'd41,8'd33,8'd25,8'd17,8'd9, 8'd1,8'd58,8'd50,8'd42,8'd34,8'd26,8'd18,
      8'd10,8'd2,8'd59,8'd51,8'd43,8'd35,8'd27, 8'd19,8'd11,8'd3,8'd60,8'd52,8'd44,8'd36,
      8'd63,8'd55,8'd47,8'd39,8'd31,8'd23,8'd15, 8'd7,8'd62,8'd54,8'd46,8'd38,8'd30,8'd22,
      8'd14,8'd6,8'd61,8'd53,8'd45,8'd37,8'd29, 8'd21,8'd13,8'd5,8'd28,8'd20,8'd12,8'd4};

   localparam idx_type TAB_PC2 [48] = '{
      8'd14,8'd17,8'd11,8'd24,8'd1,8'd5, 8'd3,8'd28,8'd15,8'd6,8'd21,8'd10,
      8'd23,8'd19,8'd12,8'd4,8'd26,8'd8, 8'd16,8'd7,8'd27,8'd20,8'd13,8'd2,
      8'd41,8'd52,8'd31,8'd37,8'd47,8'd55, 8'd30,8'd40,8'd51,8'd45,8'd33,8'd48,
      8'd44,8'd49,8'd39,8'd56,8'd34,8'd53, 8'd46,8'd42,8'd50,8'd36,8'd29,8'd32};

   localparam logic [1:0] TAB_ROT [16] = '{
      2'd1,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1};

   localparam logic [3:0] TAB_SBOX [8][64] = '{
      '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
        4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
        4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
        4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
      '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
        4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
        4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
        4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
      '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
        4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
        4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
        4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
      '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
        4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
        4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
        4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
      '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
        4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
        4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
        4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
      '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
        4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
        4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
        4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
      '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
        4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
        4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
        4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
      '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
        4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
        4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
        4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};

   function automatic logic [63:0] perm64(input logic [63:0] x);
      logic [63:0] y;
      for (int i = 0; i < 64; i++) y[63-i] = x[64-int'(TAB_IP[i])];
      return y;
   endfunction

   function automatic logic [63:0] fperm64(input logic [63:0] x);
      logic [63:0] y;
      for (int i = 0; i < 64; i++) y[63-i] = x[64-int'(TAB_FP[i])];
      return y;
   endfunction

   function automatic logic [55:0] pc1(input logic [63:0] x);
      logic [55:0] y;
      for (int i = 0; i < 56; i++) y[55-i] = x[64-int'(TAB_PC1[i])];
      return y;
   endfunction

   function automatic logic [47:0] pc2(input logic [55:0] x);
      logic [47:0] y;
      for (int i = 0; i < 48; i++) y[47-i] = x[56-int'(TAB_PC2[i])];
      return y;
   endfunction

   function automatic logic [27:0] rot28(input logic [27:0] x, input logic [1:0] s);
      logic [27:0] y;
      y = (s == 2'd1) ? {x[26:0], x[27]} : {x[25:0], x[27:26]};
      return y;
   endfunction

   // One Feistel function: expansion, key mix, S-boxes, then P.
   function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
      logic [47:0] e;
      logic [31:0] s;
      logic [31:0] p;
      logic [5:0]  six;
      for (int i = 0; i < 48; i++) e[47-i] = r[32-int'(TAB_E[i])];
      e = e ^ k;
      for (int j = 0; j < 8; j++) begin
         six = e[42-6*j +: 6];
         s[28-4*j +: 4] = TAB_SBOX[j][{six[5], six[0], six[4:1]}];
      end
      for (int i = 0; i < 32; i++) p[31-i] = s[32-int'(TAB_P[i])];
      return p;
   endfunction

endpackage

[rtl/des_block_cipher.sv]
`timescale 1ns / 1ps
// DES engine for bulk ECB traffic, one request per cycle while req_stall is low.
// Requests arrive on req_valid / req_stall with req_action (0 encrypt,
// 1 decrypt) and req_block_in; results leave on rsp_valid / rsp_stall as
// rsp_block_out. A request is taken when valid is high and stall is low.
// The key is written through csr_write_en / csr_write_data and must only
// change while no request is in flight; the sixteen round keys are
// derived from it and held in registers. The request passes the input
// permutation register, one register per Feistel round and the output
// register. Throughput is one block per cycle while req_stall is low;
// each round stage holds one S-box layer, which sets the clock period.
// The pipeline advances as a whole: while a result waits in the output
// register under rsp_stall, every stage holds and req_stall is raised.
// With the output register empty, rsp_stall has no effect on the pipeline.
// Reset (synchronous, active high) empties the pipeline and clears the
// key to zero.
module des_block_cipher (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_action,
   input  logic [des_pkg::BlockWidth-1:0]    req_block_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [des_pkg::BlockWidth-1:0]    rsp_block_out,
   input  logic                              csr_write_en,
   input  logic [des_pkg::KeyWidth-1:0]      csr_write_data
);
   import des_pkg::*;

   localparam int Stages = Rounds + 1;

   logic [KeyWidth-1:0] key_ff;
   logic [SubWidth-1:0] sub_ff [Rounds];
   logic [SubWidth-1:0] sub_in [Rounds];

   logic                   vld_ff [Stages];
   logic                   dec_ff [Stages];
   logic [HalfWidth-1:0]   l_ff   [Stages];
   logic [HalfWidth-1:0]   r_ff   [Stages];
   logic                   out_vld_ff;
   logic [BlockWidth-1:0]  out_ff;
   logic                   advance;
   logic [BlockWidth-1:0]  ip_in;

   assign advance   = !(out_vld_ff && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = out_vld_ff;
   assign rsp_block_out = out_ff;
   assign ip_in = perm64(req_block_in);

   always_comb begin
      logic [27:0] c, d;
      logic [55:0] k56;
      k56 = pc1(key_ff);
      c = k56[55:28];
      d = k56[27:0];
      for (int i = 0; i < Rounds; i++) begin
         c = rot28(c, TAB_ROT[i]);
         d = rot28(d, TAB_ROT[i]);
         sub_in[i] = pc2({c, d});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_write_en) begin
         key_ff <= csr_write_data;
      end
      for (int i = 0; i < Rounds; i++) sub_ff[i] <= sub_in[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < Stages; s++) vld_ff[s] <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= req_valid;
         for (int s = 1; s < Stages; s++) vld_ff[s] <= vld_ff[s-1];
         out_vld_ff <= vld_ff[Stages-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dec_ff[0] <= req_action;
         l_ff[0]   <= ip_in[63:32];
         r_ff[0]   <= ip_in[31:0];
         for (int s = 1; s < Stages; s++) begin
            dec_ff[s] <= dec_ff[s-1];
            if (s == Rounds) begin
               l_ff[s] <= l_ff[s-1] ^ feistel(r_ff[s-1],
                  dec_ff[s-1] ? sub_ff[Rounds-s] : sub_ff[s-1]);
               r_ff[s] <= r_ff[s-1];
            end else begin
               l_ff[s] <= r_ff[s-1];
               r_ff[s] <= l_ff[s-1] ^ feistel(r_ff[s-1],
                  dec_ff[s-1] ? sub_ff[Rounds-s] : sub_ff[s-1]);
            end
         end
         out_ff <= fperm64({l_ff[Stages-1], r_ff[Stages-1]});
      end
   end

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid) else $error("input stalled with empty output");
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_block_out)))
      else $error("stalled result changed");
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (!rsp_stall && vld_ff[Stages-1]) |=> rsp_valid)
      else $error("last stage lost a request");

endmodule
